/* sv/fef_pkg.sv */
// Shared types, constants and byte-stuffing helpers for the flag/escape/XOR framer.
package fef_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // One classified input item, ready for the output sequencer.
  typedef struct packed {
    logic       open;
    logic [7:0] data;
    logic       close;
    logic [7:0] csum;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_DATA,
    ST_DATA_ESC,
    ST_CSUM,
    ST_CSUM_ESC,
    ST_CLOSE
  } step_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FOR_FLAG : ESC_FOR_ESC;
  endfunction

endpackage

/* sv/fef_front.sv */
// Front end: accepts input items, keeps the running XOR checksum, builds jobs.
module fef_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fef_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             full,
  output logic             enq,
  output fef_pkg::job_t    enq_job
);
  import fef_pkg::*;

  logic [7:0] running_xor;
  logic [7:0] running_xor_next;
  logic [7:0] csum;

  assign full = q_full;
  assign enq  = push && !q_full;

  assign csum = (in_item.first_byte ? 8'h00 : running_xor) ^ in_item.data_byte;
  assign running_xor_next = in_item.last_byte ? 8'h00 : csum;

  always_comb begin
    enq_job.open  = in_item.first_byte;
    enq_job.data  = in_item.data_byte;
    enq_job.close = in_item.last_byte;
    enq_job.csum  = csum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor <= 8'h00;
    end else if (enq) begin
      running_xor <= running_xor_next;
    end
  end

endmodule

/* sv/fef_queue.sv */
// Short job queue between front end and output sequencer.
module fef_queue #(
  parameter int DEPTH = fef_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          enq,
  input  fef_pkg::job_t enq_job,
  output logic          q_full,
  input  logic          deq,
  output logic          head_valid,
  output fef_pkg::job_t head_job
);
  import fef_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full     = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/fef_back.sv */
// Output sequencer: expands each job into framed bytes through an output register.
module fef_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  fef_pkg::job_t     head_job,
  output logic              deq,
  output logic              empty,
  input  logic              pop,
  output fef_pkg::out_item_t out_item
);
  import fef_pkg::*;

  step_t     step;
  step_t     step_next;
  step_t     cur;
  logic      out_valid;
  logic      load;
  logic      job_done;
  out_item_t item_next;

  assign load  = head_valid && (!out_valid || pop);
  assign empty = !out_valid;
  assign deq   = load && job_done;
  assign cur   = (step != ST_IDLE) ? step : (head_job.open ? ST_OPEN : ST_DATA);

  // next state
  always_comb begin
    step_next = step;
    if (load) begin
      unique case (cur)
        ST_OPEN:     step_next = ST_DATA;
        ST_DATA:     step_next = needs_esc(head_job.data) ? ST_DATA_ESC :
                                 (head_job.close ? ST_CSUM : ST_IDLE);
        ST_DATA_ESC: step_next = head_job.close ? ST_CSUM : ST_IDLE;
        ST_CSUM:     step_next = needs_esc(head_job.csum) ? ST_CSUM_ESC : ST_CLOSE;
        ST_CSUM_ESC: step_next = ST_CLOSE;
        ST_CLOSE:    step_next = ST_IDLE;
        default:     step_next = ST_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    item_next = '0;
    job_done  = 1'b0;
    unique case (cur)
      ST_OPEN: begin
        item_next.out_byte = FLAG_BYTE;
      end
      ST_DATA: begin
        if (needs_esc(head_job.data)) begin
          item_next.out_byte = ESC_BYTE;
        end else begin
          item_next.out_byte = head_job.data;
          job_done = !head_job.close;
        end
      end
      ST_DATA_ESC: begin
        item_next.out_byte = esc_code(head_job.data);
        job_done = !head_job.close;
      end
      ST_CSUM: begin
        item_next.out_byte = needs_esc(head_job.csum) ? ESC_BYTE : head_job.csum;
      end
      ST_CSUM_ESC: begin
        item_next.out_byte = esc_code(head_job.csum);
      end
      ST_CLOSE: begin
        item_next.out_byte  = FLAG_BYTE;
        item_next.frame_end = 1'b1;
        job_done = 1'b1;
      end
      default: begin
        item_next.out_byte = FLAG_BYTE;
      end
    endcase
    item_next.run_last = job_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

/* sv/flag_escape_xor_framer.sv */
// Top level of the flag/escape/XOR framer.
// Frames a byte stream: an opening 0x7E on a first byte, each byte stuffed
// (0x7E -> 0x7D 0x02, 0x7D -> 0x7D 0x01), and after a last byte the stuffed
// XOR checksum and a closing 0x7E. The front end takes one item per cycle
// while its job queue (QUEUE_DEPTH entries) has room; the output sequencer
// sends one byte per cycle while the receiver keeps popping, and an item
// expands to 1 to 6 output bytes (1 for a plain middle byte, 2 for a
// stuffed one, up to 6 for a one-byte message with stuffing). The output
// byte rate sets sustained throughput. Bytes reach the result side through
// the job queue and then the output register.
module flag_escape_xor_framer #(
  parameter int QUEUE_DEPTH = fef_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  fef_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output fef_pkg::out_item_t out_item
);
  import fef_pkg::*;

  logic q_full;
  logic enq;
  job_t enq_job;
  logic deq;
  logic head_valid;
  job_t head_job;

  fef_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .full    (full),
    .enq     (enq),
    .enq_job (enq_job)
  );

  fef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .enq        (enq),
    .enq_job    (enq_job),
    .q_full     (q_full),
    .deq        (deq),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  fef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .deq        (deq),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

/* tb/sv/flag_escape_xor_framer_tb.sv */
// Self-checking testbench for the flag/escape/XOR byte-stuffing framer.
`timescale 1ns / 1ps

module flag_escape_xor_framer_tb;
  import fef_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 16;
  localparam int MAX_PRINTS = 40;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_item_t in_item = '0;
  out_item_t out_item;

  out_item_t expected_bytes[$];
  logic [7:0] frame_xor;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  flag_escape_xor_framer dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  function automatic out_item_t framed(input logic [7:0] b, input logic fe);
    out_item_t r;
    r.out_byte = b;
    r.run_last = 1'b0;
    r.frame_end = fe;
    return r;
  endfunction

  function automatic void append_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE) begin
      expected_bytes.push_back(framed(ESC_BYTE, 1'b0));
      expected_bytes.push_back(framed(ESC_FOR_FLAG, 1'b0));
    end else if (b == ESC_BYTE) begin
      expected_bytes.push_back(framed(ESC_BYTE, 1'b0));
      expected_bytes.push_back(framed(ESC_FOR_ESC, 1'b0));
    end else begin
      expected_bytes.push_back(framed(b, 1'b0));
    end
  endfunction

  // Expected bytes for one accepted item; updates the running checksum.
  function automatic void frame_item(input in_item_t it);
    out_item_t tail;
    if (it.first_byte) begin
      expected_bytes.push_back(framed(FLAG_BYTE, 1'b0));
      frame_xor = 8'h00;
    end
    frame_xor = frame_xor ^ it.data_byte;
    append_stuffed(it.data_byte);
    if (it.last_byte) begin
      append_stuffed(frame_xor);
      expected_bytes.push_back(framed(FLAG_BYTE, 1'b1));
      frame_xor = 8'h00;
    end
    tail = expected_bytes.pop_back();
    tail.run_last = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  // Check first, then predict: an item's bytes never leave on its own edge.
  always @(posedge clk) begin
    out_item_t exp_b;
    if (rst) begin
      frame_xor = 8'h00;
      expected_bytes.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_item.out_byte));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_item.out_byte !== exp_b.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_item.out_byte, exp_b.out_byte));
          if (out_item.run_last !== exp_b.run_last)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      out_item.run_last, exp_b.run_last));
          if (out_item.frame_end !== exp_b.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      out_item.frame_end, exp_b.frame_end));
        end
      end
      if (push && !full) begin
        frame_item(in_item);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("[flag_escape_xor_framer] ERROR");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_item(input logic [7:0] b, input logic f, input logic l);
    in_item_t it;
    it.data_byte = b;
    it.first_byte = f;
    it.last_byte = l;
    return it;
  endfunction

  // Bias toward the two stuffed values.
  function automatic logic [7:0] rand_byte();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return FLAG_BYTE;
    if (sel == 1) return ESC_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
  endtask

  task automatic send_frames(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_item(mk_item(rand_byte(), 1'($urandom_range(1)), 1'($urandom_range(1))));
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          send_item(mk_item(rand_byte(), i == 0, i == len - 1));
        end
        sent += len;
      end
    end
  endtask

  task automatic test_edge_cases();
    // byte with no opening first, straight after reset
    send_item(mk_item(8'h7E, 1'b0, 1'b0));
    send_item(mk_item(8'h11, 1'b0, 1'b1));
    // one-byte messages, including both stuffed values
    send_item(mk_item(8'h00, 1'b1, 1'b1));
    send_item(mk_item(8'hFF, 1'b1, 1'b1));
    send_item(mk_item(8'h7E, 1'b1, 1'b1));
    send_item(mk_item(8'h7D, 1'b1, 1'b1));
    // stuffed data, checksum comes out zero
    send_item(mk_item(8'h7E, 1'b1, 1'b0));
    send_item(mk_item(8'h7D, 1'b0, 1'b0));
    send_item(mk_item(8'h03, 1'b0, 1'b1));
    // checksum needs stuffing
    send_item(mk_item(8'h01, 1'b1, 1'b0));
    send_item(mk_item(8'h7C, 1'b0, 1'b1));
    // restart inside a message
    send_item(mk_item(8'h55, 1'b1, 1'b0));
    send_item(mk_item(8'hAA, 1'b0, 1'b0));
    send_item(mk_item(8'h12, 1'b1, 1'b0));
    send_item(mk_item(8'h34, 1'b0, 1'b1));
    // bytes with no opening first after a closed frame
    send_item(mk_item(8'h7D, 1'b0, 1'b0));
    send_item(mk_item(8'h80, 1'b0, 1'b1));
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_frames(70);
  endtask

  task automatic test_sparse_sender();
    send_idle_pct = 83;
    pop_stall_pct = 0;
    send_frames(70);
  endtask

  task automatic test_stalled_receiver();
    send_idle_pct = 0;
    pop_stall_pct = 83;
    send_frames(70);
  endtask

  task automatic test_mixed_idle();
    send_idle_pct = 7;
    pop_stall_pct = 7;
    send_frames(70);
  endtask

  task automatic test_input_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_request = 1'b1;
    send_frames(40);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_edge_cases();
    test_streaming();
    test_sparse_sender();
    test_stalled_receiver();
    test_mixed_idle();
    test_input_backpressure();
    push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("[flag_escape_xor_framer] OK");
    end else begin
      $display("[flag_escape_xor_framer] ERROR");
    end
    $finish;
  end

endmodule
